// ===== hdl/ktmr_pkg.sv =====
package ktmr_pkg;

  localparam int unsigned NUM_DIGITS = 4;

  localparam logic [6:0] MAX_MIN_RST  = 7'd30;
  localparam logic [6:0] SEC_LIMIT    = 7'd60;
  localparam logic [3:0] DIGIT_MAX    = 4'd9;
  localparam logic [3:0] SEC_TENS_MAX = 4'd5;

  localparam logic [4:0] KEY_DIGIT_LAST  = 5'd9;
  localparam logic [4:0] KEY_LETTER_LAST = 5'd15;
  localparam logic [4:0] KEY_R           = 5'd16;
  localparam logic [4:0] KEY_S           = 5'd17;

  typedef enum logic [2:0] {
    REQ_KEY        = 3'd0,
    REQ_TICK       = 3'd1,
    REQ_START      = 3'd2,
    REQ_STOP       = 3'd3,
    REQ_DOOR_OPEN  = 3'd4,
    REQ_DOOR_CLOSE = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    MODE_ENTER = 3'd0,
    MODE_AWAIT = 3'd1,
    MODE_RUN   = 3'd2,
    MODE_PAUSE = 3'd3,
    MODE_DOOR  = 3'd4,
    MODE_DONE  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_CHAR_ERR = 3'd1,
    ST_OVER_MAX = 3'd2,
    ST_SEC_ERR  = 3'd3,
    ST_FINISHED = 3'd4,
    ST_STOPPED  = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [4:0] key_code;
    logic       door_closed;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [3:0] sec_tens;
    logic [3:0] sec_ones;
    logic       leds_on;
    logic [2:0] status;
  } out_item_t;

endpackage

// ===== hdl/keypad_countdown_timer.sv =====
// Cooking timer controller for an mm:ss keypad entry. Every input transfer
// (key, one-second tick, start, stop/pause, door opened, door closed) gives
// exactly one result transfer carrying mode, the four shown digits, lamp
// state and a status code. The whole update is one combinational pass from
// the state registers into a result register, so a new transfer is taken
// every cycle while in_stall_o is low. Its result is registered into the
// result register, or into the skid register while the result register is held.
// This two-entry output buffer keeps input transfers flowing while one result
// waits; in_stall_o rises only when both entries are full. max_minutes is
// to be written through cfg_we_i/cfg_wdata_i only while the block is idle (not enforced); it resets to 30.
module keypad_countdown_timer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ktmr_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ktmr_pkg::out_item_t  out_data_o
);

  // timer state: digit 0 is seconds ones, digit 3 is minutes tens
  logic [ktmr_pkg::NUM_DIGITS-1:0][3:0] dig_q, dig_d;
  logic [2:0]      cnt_q, cnt_d;
  ktmr_pkg::mode_e mode_q, mode_d;
  logic            lamp_q, lamp_d;
  logic [6:0]      max_min_q;

  // output buffer
  ktmr_pkg::out_item_t out_q, skid_q, res;
  logic                out_vld_q, skid_vld_q;

  // working values
  logic [ktmr_pkg::NUM_DIGITS-1:0][3:0] dig_e;
  logic [2:0]          cnt_e;
  ktmr_pkg::mode_e     mode_e_v;
  logic [6:0]          mins, secs;
  logic                over_max, sec_bad;
  logic                do_shift, do_clear, do_start;
  logic [3:0]          shift_val;
  logic [3:0]          cnt_inc;
  ktmr_pkg::status_e   status;
  logic [ktmr_pkg::NUM_DIGITS-1:0][3:0] shown;

  logic in_xfer, out_xfer;
  logic [2:0] req;
  logic [4:0] key;

  assign in_stall_o  = skid_vld_q;
  assign in_xfer     = in_valid_i && !skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_xfer    = out_vld_q && !out_stall_i;
  assign out_data_o  = out_q;

  assign req = in_data_i.req_type;
  assign key = in_data_i.key_code;

  // a key after a finished run starts a fresh entry before it is handled
  always_comb begin
    if (mode_q == ktmr_pkg::MODE_DONE && req == ktmr_pkg::REQ_KEY) begin
      dig_e    = '0;
      cnt_e    = 3'd0;
      mode_e_v = ktmr_pkg::MODE_ENTER;
    end else begin
      dig_e    = dig_q;
      cnt_e    = cnt_q;
      mode_e_v = mode_q;
    end
  end

  // start check: minutes and seconds as binary, times ten by shift and add
  assign mins = ({3'b000, dig_e[3]} << 3) + ({3'b000, dig_e[3]} << 1) + {3'b000, dig_e[2]};
  assign secs = ({3'b000, dig_e[1]} << 3) + ({3'b000, dig_e[1]} << 1) + {3'b000, dig_e[0]};
  assign over_max = (mins > max_min_q) || (mins == max_min_q && secs != 7'd0);
  assign sec_bad  = (secs >= ktmr_pkg::SEC_LIMIT);
  assign cnt_inc  = {1'b0, cnt_e} + 4'd1;

  always_comb begin
    dig_d     = dig_e;
    cnt_d     = cnt_e;
    mode_d    = mode_e_v;
    lamp_d    = lamp_q;
    status    = ktmr_pkg::ST_NONE;
    do_shift  = 1'b0;
    do_clear  = 1'b0;
    do_start  = 1'b0;
    shift_val = 4'd0;

    unique case (mode_e_v)
      ktmr_pkg::MODE_ENTER: begin
        if (req == ktmr_pkg::REQ_KEY) begin
          if (key <= ktmr_pkg::KEY_DIGIT_LAST) begin
            do_shift  = 1'b1;
            shift_val = key[3:0];
          end else if (key <= ktmr_pkg::KEY_LETTER_LAST) begin
            status = ktmr_pkg::ST_CHAR_ERR;
          end else if (key == ktmr_pkg::KEY_R || key == ktmr_pkg::KEY_S) begin
            // R or S as the first key counts as a zero digit
            if (cnt_e == 3'd0) begin
              do_shift = 1'b1;
            end else if (key == ktmr_pkg::KEY_R) begin
              do_clear = 1'b1;
            end else begin
              do_start = 1'b1;
            end
          end
        end
      end
      ktmr_pkg::MODE_AWAIT: begin
        if (req == ktmr_pkg::REQ_START && in_data_i.door_closed) begin
          do_start = 1'b1;
        end else if (req == ktmr_pkg::REQ_STOP) begin
          do_clear = 1'b1;
        end
      end
      ktmr_pkg::MODE_RUN: begin
        if (req == ktmr_pkg::REQ_TICK) begin
          if (dig_e == '0) begin
            mode_d = ktmr_pkg::MODE_DONE;
            lamp_d = 1'b0;
            status = ktmr_pkg::ST_FINISHED;
          end else if (dig_e[0] != 4'd0) begin
            dig_d[0] = dig_e[0] - 4'd1;
          end else if (dig_e[1] != 4'd0) begin
            dig_d[1] = dig_e[1] - 4'd1;
            dig_d[0] = ktmr_pkg::DIGIT_MAX;
          end else if (dig_e[2] != 4'd0) begin
            dig_d[2] = dig_e[2] - 4'd1;
            dig_d[1] = ktmr_pkg::SEC_TENS_MAX;
            dig_d[0] = ktmr_pkg::DIGIT_MAX;
          end else begin
            dig_d[3] = dig_e[3] - 4'd1;
            dig_d[2] = ktmr_pkg::DIGIT_MAX;
            dig_d[1] = ktmr_pkg::SEC_TENS_MAX;
            dig_d[0] = ktmr_pkg::DIGIT_MAX;
          end
        end else if (req == ktmr_pkg::REQ_STOP) begin
          mode_d = ktmr_pkg::MODE_PAUSE;
        end else if (req == ktmr_pkg::REQ_DOOR_OPEN) begin
          mode_d = ktmr_pkg::MODE_DOOR;
        end
      end
      ktmr_pkg::MODE_PAUSE: begin
        if (req == ktmr_pkg::REQ_TICK) begin
          lamp_d = !lamp_q;
        end else if (req == ktmr_pkg::REQ_STOP) begin
          mode_d = ktmr_pkg::MODE_DONE;
          lamp_d = 1'b0;
          status = ktmr_pkg::ST_STOPPED;
        end else if (req == ktmr_pkg::REQ_START) begin
          mode_d = ktmr_pkg::MODE_RUN;
          lamp_d = 1'b1;
        end
      end
      ktmr_pkg::MODE_DOOR: begin
        if (req == ktmr_pkg::REQ_TICK) begin
          lamp_d = !lamp_q;
        end else if (req == ktmr_pkg::REQ_DOOR_CLOSE) begin
          mode_d = ktmr_pkg::MODE_RUN;
          lamp_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_shift) begin
      dig_d = {dig_e[2:0], shift_val};
      if (cnt_inc >= 4'(ktmr_pkg::NUM_DIGITS)) begin
        cnt_d  = 3'(ktmr_pkg::NUM_DIGITS);
        mode_d = ktmr_pkg::MODE_AWAIT;
      end else begin
        cnt_d = cnt_inc[2:0];
      end
    end

    if (do_clear) begin
      dig_d  = '0;
      cnt_d  = 3'd0;
      mode_d = ktmr_pkg::MODE_ENTER;
    end

    if (do_start) begin
      if (over_max || sec_bad) begin
        dig_d  = '0;
        cnt_d  = 3'd0;
        mode_d = ktmr_pkg::MODE_ENTER;
        status = over_max ? ktmr_pkg::ST_OVER_MAX : ktmr_pkg::ST_SEC_ERR;
      end else begin
        mode_d = ktmr_pkg::MODE_RUN;
        lamp_d = 1'b1;
      end
    end
  end

  // a tick while running shows the time before the countdown step
  assign shown = (mode_q == ktmr_pkg::MODE_RUN && req == ktmr_pkg::REQ_TICK) ? dig_q : dig_d;

  always_comb begin
    res.mode     = mode_d;
    res.min_tens = shown[3];
    res.min_ones = shown[2];
    res.sec_tens = shown[1];
    res.sec_ones = shown[0];
    res.leds_on  = lamp_d;
    res.status   = status;
  end

  // state registers, updated on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q  <= '0;
      cnt_q  <= 3'd0;
      mode_q <= ktmr_pkg::MODE_ENTER;
      lamp_q <= 1'b0;
    end else if (in_xfer) begin
      dig_q  <= dig_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
      lamp_q <= lamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_min_q <= ktmr_pkg::MAX_MIN_RST;
    end else if (cfg_we_i) begin
      max_min_q <= cfg_wdata_i;
    end
  end

  // two-entry output buffer: skid fills only when the result register is
  // held by a stalled transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_xfer) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_vld_q || out_xfer) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_xfer) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (in_xfer) begin
      if (!out_vld_q || out_xfer) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  // skid entry is never occupied without the result register
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry full while result register empty");

  // lamps are dark outside a run
  a_lamp_off_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ktmr_pkg::MODE_ENTER || mode_q == ktmr_pkg::MODE_AWAIT ||
     mode_q == ktmr_pkg::MODE_DONE) |-> !lamp_q)
    else $error("lamps on outside a run");

  // every way into the running mode lights the lamps
  a_lamp_on_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ktmr_pkg::MODE_RUN) |-> lamp_q)
    else $error("lamps off while running");

  // awaiting start only with a full entry
  a_await_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ktmr_pkg::MODE_AWAIT) |-> (cnt_q == 3'(ktmr_pkg::NUM_DIGITS)))
    else $error("awaiting start with a short entry");

endmodule
